/* rtl/core/mrd_pkg.sv */
// ----------------------------------------------------------------------------
// mrd_pkg
// Shared types and constants for the modem response deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package mrd_pkg;

    // framing constants
    localparam logic [7:0] START_BYTE     = 8'hD0;
    localparam logic [7:0] NAK_BYTE       = 8'h15;
    localparam logic [7:0] TYPE_MASK      = 8'h7F;
    localparam int unsigned PAYLOAD_OFFSET = 8;
    localparam int unsigned SHORT_TOTAL    = 7;
    localparam int unsigned FRAME_OVERHEAD = 5;

    // width of a byte position index inside a frame
    localparam int unsigned IDX_W = 17;

    // frame type codes, response bit removed
    localparam logic [6:0] TYPE_STATUS  = 7'h10;
    localparam logic [6:0] TYPE_HEADER  = 7'h17;
    localparam logic [6:0] TYPE_DATA    = 7'h19;
    localparam logic [6:0] TYPE_EOT     = 7'h1A;
    localparam logic [6:0] TYPE_LOST    = 7'h1B;
    localparam logic [6:0] TYPE_K11     = 7'h11;
    localparam logic [6:0] TYPE_K12     = 7'h12;
    localparam logic [6:0] TYPE_K13     = 7'h13;
    localparam logic [6:0] TYPE_K15     = 7'h15;
    localparam logic [6:0] TYPE_K16     = 7'h16;
    localparam logic [6:0] TYPE_K18     = 7'h18;

    // packed output widths
    localparam int unsigned TDATA_W = 40;
    localparam int unsigned TUSER_W = 4;

    typedef enum logic [3:0] {
        KIND_HEADER     = 4'd0,
        KIND_DATA       = 4'd1,
        KIND_EOT        = 4'd2,
        KIND_LOST       = 4'd3,
        KIND_STATUS     = 4'd4,
        KIND_HEADER_NAK = 4'd5,
        KIND_DATA_NAK   = 4'd6,
        KIND_BAD_START  = 4'd7,
        KIND_OTHER      = 4'd8,
        KIND_UNKNOWN    = 4'd9
    } t_kind;

    typedef enum logic {
        PH_HUNT  = 1'b0,
        PH_FRAME = 1'b1
    } t_phase;

    typedef struct packed {
        t_kind             kind;
        logic              last;
        logic [7:0]        payload_byte;
        logic [6:0]        msg_type;
        logic              tx_enabled;
        logic              checksum_mode;
        logic              ptt;
        logic [7:0]        tx_space;
        logic signed [8:0] free_slots;
    } t_result;

endpackage

`default_nettype wire

/* rtl/core/modem_response_deframer.sv */
// path: an accepted byte is held in the input register, and its result, if any,
// is then loaded into the result register, from which it can be taken
// throughput: one byte per cycle while no result waits, set by the single pass
// through the parser; while a result waits downstream the input register holds
// one more byte, then the input stalls until the result is taken
// reset: synchronous active-low i_rst_n empties both registers and returns
// the parser to hunting for the start byte
// ----------------------------------------------------------------------------
// modem_response_deframer
// Deframes the modem receive byte stream into payload bytes and frame reports.
// ----------------------------------------------------------------------------
`default_nettype none

module modem_response_deframer
    import mrd_pkg::*;
#(
    parameter int unsigned HEADER_PAYLOAD_BYTES = 41,
    parameter int unsigned DATA_PAYLOAD_BYTES   = 12
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  wire logic [7:0]         i_s_axis_tdata,  // [7:0] rx_byte
    output logic                    o_m_axis_tvalid,
    input  wire logic               i_m_axis_tready,
    // [7:0] payload_byte, [14:8] msg_type, [15] tx_enabled, [16] checksum_mode,
    // [17] ptt, [25:18] tx_space, [34:26] free_slots, [39:35] zero
    output logic [TDATA_W-1:0]      o_m_axis_tdata,
    output logic                    o_m_axis_tlast,
    output logic [TUSER_W-1:0]      o_m_axis_tuser   // [3:0] kind
);

    logic       in_valid;
    logic [7:0] in_byte;
    logic       advance;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    // input byte register
    mrd_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_byte    (i_s_axis_tdata),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_byte    (in_byte)
    );

    // frame parser
    mrd_parser #(
        .HEADER_PAYLOAD_BYTES (HEADER_PAYLOAD_BYTES),
        .DATA_PAYLOAD_BYTES   (DATA_PAYLOAD_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (in_valid && advance),
        .i_byte      (in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register
    mrd_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (in_valid && res_valid),
        .i_res       (res),
        .i_ready     (i_m_axis_tready),
        .o_advance   (advance),
        .o_valid     (o_m_axis_tvalid),
        .o_res       (out_res)
    );

    // output packing
    assign o_m_axis_tdata = {5'b0, out_res.free_slots, out_res.tx_space, out_res.ptt,
                             out_res.checksum_mode, out_res.tx_enabled, out_res.msg_type,
                             out_res.payload_byte};
    assign o_m_axis_tlast = out_res.last;
    assign o_m_axis_tuser = out_res.kind;

endmodule

`default_nettype wire

/* rtl/core/mrd_in_stage.sv */
// ----------------------------------------------------------------------------
// mrd_in_stage
// Input register for received bytes; refills in the cycle it is drained.
// ----------------------------------------------------------------------------
`default_nettype none

module mrd_in_stage (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_advance,
    output logic            o_valid,
    output logic [7:0]      o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    // free, or drained by the parser this cycle
    assign o_ready = !r_valid || i_advance;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // byte holding register
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

`default_nettype wire

/* rtl/core/mrd_parser.sv */
// ----------------------------------------------------------------------------
// mrd_parser
// Frame state machine: hunts for the start byte, captures the header fields
// and decides the result of each byte in one pass.
// ----------------------------------------------------------------------------
`default_nettype none

module mrd_parser
    import mrd_pkg::*;
#(
    parameter int unsigned HEADER_PAYLOAD_BYTES = 41,
    parameter int unsigned DATA_PAYLOAD_BYTES   = 12
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    output logic            o_res_valid,
    output t_result         o_res
);

    localparam logic [IDX_W-1:0] HDR_END = IDX_W'(PAYLOAD_OFFSET + HEADER_PAYLOAD_BYTES);
    localparam logic [IDX_W-1:0] DAT_END = IDX_W'(PAYLOAD_OFFSET + DATA_PAYLOAD_BYTES);
    localparam logic [IDX_W-1:0] IDX_PAY = IDX_W'(PAYLOAD_OFFSET);
    localparam logic [IDX_W-1:0] TOT_SHORT = IDX_W'(SHORT_TOTAL);
    localparam logic [IDX_W-1:0] TOT_OVH = IDX_W'(FRAME_OVERHEAD);

    t_phase           r_phase, n_phase;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [15:0]      r_len, n_len;
    logic [6:0]       r_type, n_type;
    logic [7:0]       r_b4, n_b4, r_b5, n_b5, r_b8, n_b8, r_b9, n_b9;

    logic [IDX_W-1:0] total;
    logic [IDX_W-1:0] end_idx;
    logic [IDX_W-1:0] pay_end;
    logic             is_hdr, is_dat, end_hit, fwd_ok, fwd_now;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_idx   <= '0;
            r_len   <= '0;
            r_type  <= '0;
            r_b4    <= '0;
            r_b5    <= '0;
            r_b8    <= '0;
            r_b9    <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_len   <= n_len;
            r_type  <= n_type;
            r_b4    <= n_b4;
            r_b5    <= n_b5;
            r_b8    <= n_b8;
            r_b9    <= n_b9;
        end
    end

    // field capture, including the byte being taken now; cleared at a start byte
    always_comb begin
        n_len  = r_len;
        n_type = r_type;
        n_b4   = r_b4;
        n_b5   = r_b5;
        n_b8   = r_b8;
        n_b9   = r_b9;
        if (r_phase == PH_HUNT) begin
            if (i_byte == START_BYTE) begin
                n_len  = '0;
                n_type = '0;
                n_b4   = '0;
                n_b5   = '0;
                n_b8   = '0;
                n_b9   = '0;
            end
        end else begin
            unique case (r_idx)
                IDX_W'(1): n_len  = {8'h00, i_byte};
                IDX_W'(2): n_len  = {i_byte, r_len[7:0]};
                IDX_W'(3): n_type = i_byte[6:0] & TYPE_MASK[6:0];
                IDX_W'(4): n_b4   = i_byte;
                IDX_W'(5): n_b5   = i_byte;
                IDX_W'(8): n_b8   = i_byte;
                IDX_W'(9): n_b9   = i_byte;
                default:   ;
            endcase
        end
    end

    // frame length checks
    assign total   = IDX_W'(n_len) + TOT_OVH;
    assign end_idx = IDX_W'(n_len) + IDX_W'(4);
    assign end_hit = (r_idx >= IDX_W'(4)) && (r_idx == end_idx);
    assign is_hdr  = (n_type == TYPE_HEADER);
    assign is_dat  = (n_type == TYPE_DATA);
    assign pay_end = is_hdr ? HDR_END : DAT_END;
    assign fwd_ok  = (is_hdr || is_dat) && (total != TOT_SHORT) && (total >= pay_end)
                     && !(is_hdr && n_b5[7]);
    assign fwd_now = fwd_ok && (r_idx >= IDX_PAY) && (r_idx < pay_end);

    // next state and result
    always_comb begin
        n_phase     = r_phase;
        n_idx       = r_idx;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.kind  = KIND_HEADER;
        unique case (r_phase)
            PH_HUNT: begin
                if (i_byte == START_BYTE) begin
                    n_phase = PH_FRAME;
                    n_idx   = IDX_W'(1);
                end else begin
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_BAD_START;
                end
            end
            PH_FRAME: begin
                if (end_hit) begin
                    n_phase = PH_HUNT;
                    n_idx   = '0;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
                if (fwd_now) begin
                    // forwarded payload byte
                    o_res_valid        = 1'b1;
                    o_res.kind         = is_hdr ? KIND_HEADER : KIND_DATA;
                    o_res.payload_byte = i_byte;
                    o_res.last         = (r_idx == pay_end - IDX_W'(1));
                end else if (end_hit) begin
                    // frame end report
                    o_res_valid    = 1'b1;
                    o_res.msg_type = n_type;
                    unique case (n_type)
                        TYPE_STATUS: begin
                            o_res.kind          = KIND_STATUS;
                            o_res.tx_enabled    = n_b4[1];
                            o_res.checksum_mode = n_b4[3];
                            o_res.ptt           = n_b5[1];
                            o_res.tx_space      = n_b8;
                            o_res.free_slots    = $signed({1'b0, n_b8} - {1'b0, n_b9});
                        end
                        TYPE_HEADER, TYPE_DATA: begin
                            if (total == TOT_SHORT) begin
                                if (n_b4 == NAK_BYTE) begin
                                    o_res.kind = is_hdr ? KIND_HEADER_NAK : KIND_DATA_NAK;
                                end else begin
                                    o_res.kind = KIND_OTHER;
                                end
                            end else if (fwd_ok) begin
                                o_res_valid = 1'b0;
                                o_res       = '0;
                                o_res.kind  = KIND_HEADER;
                            end else begin
                                o_res.kind = KIND_OTHER;
                            end
                        end
                        TYPE_EOT:  o_res.kind = KIND_EOT;
                        TYPE_LOST: o_res.kind = KIND_LOST;
                        TYPE_K11, TYPE_K12, TYPE_K13, TYPE_K15, TYPE_K16, TYPE_K18:
                            o_res.kind = KIND_OTHER;
                        default:   o_res.kind = KIND_UNKNOWN;
                    endcase
                end
            end
            default: begin
                n_phase = PH_HUNT;
                n_idx   = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/mrd_out_stage.sv */
// ----------------------------------------------------------------------------
// mrd_out_stage
// Result register; loads whenever empty or being taken downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module mrd_out_stage
    import mrd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_res_valid,
    input  wire t_result i_res,
    input  wire logic    i_ready,
    output logic         o_advance,
    output logic         o_valid,
    output t_result      o_res
);

    logic    r_valid;
    t_result r_res;

    // register can take a new result
    assign o_advance = !r_valid || i_ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_res_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_advance && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

/* rtl/core/mrd_checker.sv */
// ----------------------------------------------------------------------------
// mrd_checker
// Port-level checks on the deframer output stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mrd_checker
    import mrd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               o_m_axis_tvalid,
    input  wire logic               i_m_axis_tready,
    input  wire logic [TDATA_W-1:0] o_m_axis_tdata,
    input  wire logic               o_m_axis_tlast,
    input  wire logic [TUSER_W-1:0] o_m_axis_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    // tlast only on forwarded payload
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |->
            (o_m_axis_tuser == KIND_HEADER) || (o_m_axis_tuser == KIND_DATA))
        else $error("tlast on a frame report");

    // payload byte only on forwarded payload
    a_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser != KIND_HEADER) && (o_m_axis_tuser != KIND_DATA)
            |-> o_m_axis_tdata[7:0] == 8'h00)
        else $error("payload byte on a frame report");

    // status fields only on status reports
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser != KIND_STATUS) |-> o_m_axis_tdata[39:15] == '0)
        else $error("status fields outside a status report");

    // stray bytes carry no frame type
    a_bad_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == KIND_BAD_START) |-> o_m_axis_tdata[14:8] == '0)
        else $error("frame type on a stray byte");

endmodule

bind modem_response_deframer mrd_checker u_mrd_checker (.*);

`default_nettype wire
